>>> design/euler_model_normal_matrix_unit_assert.svh
// Assertion macros for the Euler model / normal matrix unit.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef EULER_MODEL_NORMAL_MATRIX_UNIT_ASSERT_SVH
`define EULER_MODEL_NORMAL_MATRIX_UNIT_ASSERT_SVH

// same-cycle implication
`define EMN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("emn: same-cycle check failed");

// next-cycle implication
`define EMN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("emn: next-cycle check failed");

`endif

>>> design/emn_pkg.sv
// Shared types, constants and divisor tables for the Euler matrix unit.
// No dependencies.
`default_nettype none
package emn_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int SIZE_BITS      = 16;
    localparam int HSTEPS         = 6;
    localparam int STEP_LAT       = 3;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic [1:0] COL_FIRST = 2'd0;
    localparam logic [1:0] COL_MOVE  = 2'd3;

    typedef struct packed {
        logic [15:0]        angle_x;
        logic [15:0]        angle_y;
        logic [15:0]        angle_z;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
        logic [15:0]        size_x;
        logic [15:0]        size_y;
        logic [15:0]        size_z;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] model_cx;
        logic signed [31:0] model_cy;
        logic signed [31:0] model_cz;
        logic signed [31:0] normal_cx;
        logic signed [31:0] normal_cy;
        logic signed [31:0] normal_cz;
        logic               scale_fault;
        logic               last_column;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] sn;
        logic signed [31:0] cs;
    } t_sincos;

    // sine series runs one step shorter: step 0 is a pass
    function automatic int sin_div(input int step);
        case (step)
            1:       return 110;
            2:       return 72;
            3:       return 42;
            4:       return 20;
            5:       return 6;
            default: return 0;
        endcase
    endfunction

    function automatic int cos_div(input int step);
        case (step)
            0:       return 132;
            1:       return 90;
            2:       return 56;
            3:       return 30;
            4:       return 12;
            default: return 2;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> design/emn_horner_step.sv
// One Horner step h' = 1 - (x2*h)/d for the sine and cosine lanes, three stages.
// Uses emn_pkg.
`default_nettype none
module emn_horner_step #(
    parameter int SDIV = 0,
    parameter int CDIV = 2
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x2,
    input  logic [30:0] i_hs,
    input  logic [30:0] i_hc,
    output logic [31:0] o_x2,
    output logic [30:0] o_hs,
    output logic [30:0] o_hc
);
    import emn_pkg::*;

    localparam int DV [2] = '{SDIV, CDIV};

    logic [31:0] r_x2a, r_x2b;
    logic [30:0] w_hin  [2];
    logic [30:0] w_hout [2];

    assign w_hin[0] = i_hs;
    assign w_hin[1] = i_hc;
    assign o_hs     = w_hout[0];
    assign o_hc     = w_hout[1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2a <= i_x2;
            r_x2b <= r_x2a;
            o_x2  <= r_x2b;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        if (DV[l] == 0) begin : g_pass
            logic [30:0] r_ha, r_hb, r_hc;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ha <= w_hin[l];
                    r_hb <= r_ha;
                    r_hc <= r_hb;
                end
            end
            assign w_hout[l] = r_hc;
        end else begin : g_step
            // reciprocal estimate is low by at most one, fixed up in the last stage
            localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / DV[l]);
            localparam logic [39:0] DCON  = 40'(DV[l]);
            logic [31:0] r_p, r_pb, r_q;
            logic [30:0] r_h;
            logic [39:0] n_rem;
            logic [31:0] n_t;
            always_comb begin
                n_rem = 40'(r_pb) - 40'(r_q) * DCON;
                n_t   = (n_rem >= DCON) ? r_q + 32'd1 : r_q;
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_p  <= 32'((64'(i_x2) * 64'(w_hin[l])) >> 30);
                    r_pb <= r_p;
                    r_q  <= 32'((64'(r_p) * 64'(RECIP)) >> 32);
                    r_h  <= (n_t >= 32'(Q30_ONE)) ? 31'd0 : 31'(32'(Q30_ONE) - n_t);
                end
            end
            assign w_hout[l] = r_h;
        end
    end

endmodule
`default_nettype wire

>>> design/emn_sincos.sv
// Fixed-point sine and cosine in Q2.30 from a first-quadrant angle and its square.
// Uses emn_pkg and emn_horner_step.
`default_nettype none
module emn_sincos (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [30:0]      i_x,
    input  logic [31:0]      i_x2,
    input  logic [1:0]       i_quad,
    output emn_pkg::t_sincos o_sc
);
    import emn_pkg::*;

    localparam int XD = HSTEPS * STEP_LAT;

    logic [31:0] w_x2 [HSTEPS+1];
    logic [30:0] w_hs [HSTEPS+1];
    logic [30:0] w_hc [HSTEPS+1];
    logic [30:0] r_xd [XD];
    logic [1:0]  r_qd [XD];

    assign w_x2[0] = i_x2;
    assign w_hs[0] = Q30_ONE;
    assign w_hc[0] = Q30_ONE;

    for (genvar s = 0; s < HSTEPS; s++) begin : g_step
        emn_horner_step #(
            .SDIV(sin_div(s)),
            .CDIV(cos_div(s))
        ) u_step (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x2  (w_x2[s]),
            .i_hs  (w_hs[s]),
            .i_hc  (w_hc[s]),
            .o_x2  (w_x2[s+1]),
            .o_hs  (w_hs[s+1]),
            .o_hc  (w_hc[s+1])
        );
    end

    logic [31:0]        n_s;
    logic [31:0]        n_si, n_ci;
    logic signed [31:0] n_sn, n_cs;

    always_comb begin
        n_s  = 32'((62'(r_xd[XD-1]) * 62'(w_hs[HSTEPS])) >> 30);
        n_si = (n_s > 32'(Q30_ONE)) ? 32'(Q30_ONE) : n_s;
        n_ci = 32'(w_hc[HSTEPS]);
        case (r_qd[XD-1])
            2'd0:    begin n_sn = n_si;  n_cs = n_ci;  end
            2'd1:    begin n_sn = n_ci;  n_cs = -n_si; end
            2'd2:    begin n_sn = -n_si; n_cs = -n_ci; end
            default: begin n_sn = -n_ci; n_cs = n_si;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xd[0] <= i_x;
            r_qd[0] <= i_quad;
            for (int i = 1; i < XD; i++) begin
                r_xd[i] <= r_xd[i-1];
                r_qd[i] <= r_qd[i-1];
            end
            o_sc.sn <= n_sn;
            o_sc.cs <= n_cs;
        end
    end

endmodule
`default_nettype wire

>>> design/emn_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband bus.
// No package dependencies.
`default_nettype none
module emn_div #(
    parameter int NW = 27,
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_sb,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_sb
);

    logic [NW-1:0] r_num [NW];
    logic [DW-1:0] r_rem [NW];
    logic [DW-1:0] r_den [NW];
    logic [SW-1:0] r_sb  [NW];

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [NW-1:0] w_n;
        logic [DW-1:0] w_r, w_d;
        logic [SW-1:0] w_s;
        logic [DW:0]   w_t;
        logic          w_ge;
        if (g == 0) begin : g_first
            assign w_n = i_num;
            assign w_r = '0;
            assign w_d = i_den;
            assign w_s = i_sb;
        end else begin : g_next
            assign w_n = r_num[g-1];
            assign w_r = r_rem[g-1];
            assign w_d = r_den[g-1];
            assign w_s = r_sb[g-1];
        end
        assign w_t  = {w_r, w_n[NW-1]};
        assign w_ge = (w_t >= {1'b0, w_d});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                // numerator shifts out at the top, quotient bits fill from the bottom
                r_num[g] <= {w_n[NW-2:0], w_ge};
                r_rem[g] <= w_ge ? DW'(w_t - {1'b0, w_d}) : w_t[DW-1:0];
                r_den[g] <= w_d;
                r_sb[g]  <= w_s;
            end
        end
    end

    assign o_quo = r_num[NW-1];
    assign o_sb  = r_sb[NW-1];

endmodule
`default_nettype wire

>>> design/euler_model_normal_matrix_unit.sv
// Euler Y-X-Z model and normal matrix unit. One input word (three angles, translation,
// per-axis Q8.8 scale) gives four output words, columns 0..3 in order; column 3 is the
// translation and carries last_column. The pipeline takes a word in any cycle in which it
// can advance; the output port moves one column per cycle while i_ready is high, and while
// the output register holds an object the whole pipeline stalls until its four columns have
// drained, ending with the translation column.
// Zero scale gives a zero model column, scale_fault and saturated (or zero) normal components.
// Depends on emn_pkg, emn_sincos, emn_horner_step, emn_div and the assertion header.
`default_nettype none
`include "euler_model_normal_matrix_unit_assert.svh"
module euler_model_normal_matrix_unit #(
    parameter int ANGLE_BITS = emn_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = emn_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  emn_pkg::t_in_word  i_word,
    output logic               o_ready,
    output logic               o_valid,
    output emn_pkg::t_out_word o_word,
    input  logic               i_ready
);
    import emn_pkg::*;

    // divider width: quotient of (mag << FRAC_BITS+9) >> 30 over the scale
    localparam int NW  = FRAC_BITS + 11;
    localparam int LD  = 26 + NW;          // input word delay line length
    localparam int LT  = LD + 1;           // total depth, output register last
    localparam int SH  = 38 - FRAC_BITS;   // model rounding shift
    localparam int SBW = 35;               // divider sideband: model, neg, nonzero, zero scale
    localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] ea, eb, p;
        ea = 64'(a);
        eb = 64'(b);
        p  = ea * eb;
        return p[61:30];   // arithmetic shift, i.e. floor
    endfunction

    function automatic logic [31:0] pack(input logic [63:0] mag, input logic neg);
        if (neg) begin
            if (mag >= 64'h8000_0000) return 32'h8000_0000;
            return 32'(64'h1_0000_0000 - mag);
        end
        if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    // ---------------- control ----------------
    // every stage moves together; the output register is only refilled once
    // its translation column has been taken
    logic [LT-1:0] r_vld;
    logic [1:0]    r_col;
    logic          w_en;

    assign w_en    = !r_vld[LT-1] || (i_ready && r_col == COL_MOVE);
    assign o_ready = w_en;
    assign o_valid = r_vld[LT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_col <= COL_FIRST;
        end else begin
            if (w_en) r_vld <= {r_vld[LT-2:0], i_valid};
            if (o_valid && i_ready) r_col <= r_col + 2'd1;
        end
    end

    // input word rides alongside for scale and translation
    t_in_word r_dly [LD];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly[0] <= i_word;
            for (int i = 1; i < LD; i++) r_dly[i] <= r_dly[i-1];
        end
    end

    // ---------------- angle reduction ----------------
    // lane 0: yaw (s1,c1), lane 1: pitch (s2,c2), lane 2: roll (s3,c3)
    logic [15:0] w_ang [3];
    assign w_ang[0] = i_word.angle_y;
    assign w_ang[1] = i_word.angle_x;
    assign w_ang[2] = i_word.angle_z;

    logic [31:0] n_turn [3];
    logic [30:0] n_x    [3];
    logic [31:0] n_x2   [3];
    logic [30:0] r_x1   [3];
    logic [1:0]  r_q1   [3];
    logic [30:0] r_xb   [3];
    logic [1:0]  r_qb   [3];
    logic [31:0] r_x2   [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_turn[l] = (32'(w_ang[l]) & AMASK) << (32 - ANGLE_BITS);
            n_x[l]    = 31'((61'(n_turn[l][29:0]) * 61'(HALF_PI_Q30)) >> 30);
            n_x2[l]   = 32'((62'(r_x1[l]) * 62'(r_x1[l])) >> 30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_x1[l] <= n_x[l];
                r_q1[l] <= n_turn[l][31:30];
                r_x2[l] <= n_x2[l];
                r_xb[l] <= r_x1[l];
                r_qb[l] <= r_q1[l];
            end
        end
    end

    t_sincos w_sc [3];
    for (genvar l = 0; l < 3; l++) begin : g_sc
        emn_sincos u_sc (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_x    (r_xb[l]),
            .i_x2   (r_x2[l]),
            .i_quad (r_qb[l]),
            .o_sc   (w_sc[l])
        );
    end

    // ---------------- basis vectors ----------------
    logic signed [31:0] r_c1c3, r_s1s2, r_c2s3, r_c1s2, r_c3s1;
    logic signed [31:0] r_c1s3, r_c2c3, r_s1s3, r_c2s1, r_c1c2, r_s2, r_s3;
    logic signed [31:0] r_s1s2s3, r_c1s2s3, r_c3s1s2, r_c1c3s2;
    logic signed [31:0] r_c1c3_d, r_c2s3_d, r_c3s1_d, r_c1s3_d, r_c2c3_d;
    logic signed [31:0] r_s1s3_d, r_c2s1_d, r_c1c2_d, r_s2_d;
    logic signed [32:0] r_b [9];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1c3 <= mulq(w_sc[0].cs, w_sc[2].cs);
            r_s1s2 <= mulq(w_sc[0].sn, w_sc[1].sn);
            r_c2s3 <= mulq(w_sc[1].cs, w_sc[2].sn);
            r_c1s2 <= mulq(w_sc[0].cs, w_sc[1].sn);
            r_c3s1 <= mulq(w_sc[2].cs, w_sc[0].sn);
            r_c1s3 <= mulq(w_sc[0].cs, w_sc[2].sn);
            r_c2c3 <= mulq(w_sc[1].cs, w_sc[2].cs);
            r_s1s3 <= mulq(w_sc[0].sn, w_sc[2].sn);
            r_c2s1 <= mulq(w_sc[1].cs, w_sc[0].sn);
            r_c1c2 <= mulq(w_sc[0].cs, w_sc[1].cs);
            r_s2   <= w_sc[1].sn;
            r_s3   <= w_sc[2].sn;

            r_s1s2s3 <= mulq(r_s1s2, r_s3);
            r_c1s2s3 <= mulq(r_c1s2, r_s3);
            r_c3s1s2 <= mulq(r_c3s1, r_s2);
            r_c1c3s2 <= mulq(r_c1c3, r_s2);
            r_c1c3_d <= r_c1c3;
            r_c2s3_d <= r_c2s3;
            r_c3s1_d <= r_c3s1;
            r_c1s3_d <= r_c1s3;
            r_c2c3_d <= r_c2c3;
            r_s1s3_d <= r_s1s3;
            r_c2s1_d <= r_c2s1;
            r_c1c2_d <= r_c1c2;
            r_s2_d   <= r_s2;

            r_b[0] <= 33'(r_c1c3_d) + 33'(r_s1s2s3);
            r_b[1] <= 33'(r_c2s3_d);
            r_b[2] <= 33'(r_c1s2s3) - 33'(r_c3s1_d);
            r_b[3] <= 33'(r_c3s1s2) - 33'(r_c1s3_d);
            r_b[4] <= 33'(r_c2c3_d);
            r_b[5] <= 33'(r_c1c3s2) + 33'(r_s1s3_d);
            r_b[6] <= 33'(r_c2s1_d);
            r_b[7] <= -33'(r_s2_d);
            r_b[8] <= 33'(r_c1c2_d);
        end
    end

    // ---------------- magnitude, model column, divider operand ----------------
    logic [15:0]         w_size [3];
    logic [31:0]         n_mag  [9];
    logic [31:0]         r_mag6 [9];
    logic                r_neg6 [9];
    logic [15:0]         r_scl6 [9];
    logic [48:0]         n_prod [9];
    logic [48:0]         n_mr   [9];
    logic [FRAC_BITS+40:0] n_ext [9];
    logic [31:0]         r_mdl7 [9];
    logic [NW-1:0]       r_m7   [9];
    logic [15:0]         r_s7   [9];
    logic                r_neg7 [9];
    logic                r_nz7  [9];
    logic                r_zs7  [9];

    assign w_size[0] = r_dly[23].size_x;
    assign w_size[1] = r_dly[23].size_y;
    assign w_size[2] = r_dly[23].size_z;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_mag[k]  = r_b[k][32] ? 32'(-r_b[k]) : r_b[k][31:0];
            n_prod[k] = 49'(r_mag6[k]) * 49'(r_scl6[k]) + (49'd1 << (SH - 1));
            n_mr[k]   = n_prod[k] >> SH;
            n_ext[k]  = {r_mag6[k], {(FRAC_BITS + 9){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                for (int j = 0; j < 3; j++) begin
                    r_mag6[c*3+j] <= n_mag[c*3+j];
                    r_neg6[c*3+j] <= r_b[c*3+j][32];
                    r_scl6[c*3+j] <= w_size[c];
                end
            end
            for (int k = 0; k < 9; k++) begin
                r_mdl7[k] <= pack(64'(n_mr[k]), r_neg6[k] && n_mr[k] != 49'd0);
                r_m7[k]   <= n_ext[k][FRAC_BITS+40:30];
                r_s7[k]   <= r_scl6[k];
                r_neg7[k] <= r_neg6[k];
                r_nz7[k]  <= (r_mag6[k] != 32'd0);
                r_zs7[k]  <= (r_scl6[k] == 16'd0);
            end
        end
    end

    // ---------------- normal column: twice-quotient, then round half up ----------------
    logic [NW-1:0]  w_quo [9];
    logic [SBW-1:0] w_sb  [9];

    for (genvar k = 0; k < 9; k++) begin : g_div
        emn_div #(
            .NW (NW),
            .DW (SIZE_BITS),
            .SW (SBW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_m7[k]),
            .i_den (r_s7[k]),
            .i_sb  ({r_mdl7[k], r_neg7[k], r_nz7[k], r_zs7[k]}),
            .o_quo (w_quo[k]),
            .o_sb  (w_sb[k])
        );
    end

    logic [NW:0]  n_qr  [9];
    logic [31:0]  n_nrm [9];
    t_out_word    n_res [4];
    t_out_word    r_res [4];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_qr[k] = ({1'b0, w_quo[k]} + (NW + 1)'(1)) >> 1;
            if (w_sb[k][0]) begin
                // zero scale: zero for a zero basis component, else full scale with its sign
                if (!w_sb[k][1]) n_nrm[k] = 32'd0;
                else n_nrm[k] = w_sb[k][2] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                n_nrm[k] = pack(64'(n_qr[k]), w_sb[k][2] && n_qr[k] != '0);
            end
        end
        for (int c = 0; c < 3; c++) begin
            n_res[c].column_index = 2'(c);
            n_res[c].model_cx     = w_sb[c*3][34:3];
            n_res[c].model_cy     = w_sb[c*3+1][34:3];
            n_res[c].model_cz     = w_sb[c*3+2][34:3];
            n_res[c].normal_cx    = n_nrm[c*3];
            n_res[c].normal_cy    = n_nrm[c*3+1];
            n_res[c].normal_cz    = n_nrm[c*3+2];
            n_res[c].scale_fault  = w_sb[c*3][0];
            n_res[c].last_column  = 1'b0;
        end
        n_res[3].column_index = COL_MOVE;
        n_res[3].model_cx     = r_dly[LD-1].move_x;
        n_res[3].model_cy     = r_dly[LD-1].move_y;
        n_res[3].model_cz     = r_dly[LD-1].move_z;
        n_res[3].normal_cx    = '0;
        n_res[3].normal_cy    = '0;
        n_res[3].normal_cz    = '0;
        n_res[3].scale_fault  = 1'b0;
        n_res[3].last_column  = 1'b1;
    end

    // output register: all four columns, read out one word per cycle while i_ready is high
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 4; c++) r_res[c] <= n_res[c];
        end
    end

    assign o_word = r_res[r_col];

    // ---------------- checks ----------------
    `EMN_ASSERT_NOW(a_idle_col, !o_valid, r_col == COL_FIRST)
    `EMN_ASSERT_NEXT(a_hold_out, o_valid && !(i_ready && r_col == COL_MOVE), o_valid)
    `EMN_ASSERT_NEXT(a_col_step, o_valid && i_ready && r_col != COL_MOVE,
                     o_valid && r_col == $past(r_col) + 2'd1)

endmodule
`default_nettype wire

>>> tb/sv/euler_model_normal_matrix_unit_tb.sv
// Testbench for euler_model_normal_matrix_unit: directed and random transforms, four
// expected columns predicted per word and checked in order at the output handshake.
// Depends on emn_pkg and the unit under test.
`timescale 1ns / 1ps
module euler_model_normal_matrix_unit_tb;
    import emn_pkg::*;

    localparam longint unsigned ONE_Q30   = 64'd1 << 30;
    localparam longint unsigned HPI_Q30   = 64'd1686629713;
    localparam int              TAIL_WAIT = 120;     // well past the pipeline latency
    localparam int              CYC_LIMIT = 600000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    t_in_word   i_word = '0;
    logic       o_ready;
    logic       o_valid;
    t_out_word  o_word;
    logic       i_ready = 1'b0;

    t_out_word  column_q[$];        // expected columns, oldest first
    int         err_cnt = 0;
    int         cyc_cnt = 0;
    int         tx_idle_pct = 0;    // sender gap chance, per cent
    int         rx_idle_pct = 0;    // receiver stall chance, per cent
    int         rx_hold = 0;        // cycles of forced receiver hold-off

    euler_model_normal_matrix_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_word  (o_word),
        .i_ready (i_ready)
    );

    always #2 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYC_LIMIT) begin
            $display("euler_model_normal_matrix_unit_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: truncated Taylor sine/cosine in Q30, Y-X-Z basis, then
    // scale (model) and inverse scale (normal) with half-away rounding.
    // ------------------------------------------------------------------
    function automatic longint unsigned taylor_poly(input longint unsigned x2,
                                                    input bit is_cos);
        longint unsigned h;
        longint unsigned t;
        longint unsigned dv;
        int              n;
        h = ONE_Q30;
        n = is_cos ? 6 : 5;
        for (int k = 0; k < n; k++) begin
            if (is_cos)
                case (k)
                    0: dv = 132; 1: dv = 90; 2: dv = 56;
                    3: dv = 30;  4: dv = 12; default: dv = 2;
                endcase
            else
                case (k)
                    0: dv = 110; 1: dv = 72; 2: dv = 42;
                    3: dv = 20;  default: dv = 6;
                endcase
            t = ((x2 * h) >> 30) / dv;
            h = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        end
        return h;
    endfunction

    task automatic angle_sincos(input logic [15:0] ang, output longint sn,
                                output longint cs);
        longint unsigned turn;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned s;
        longint          si;
        longint          ci;
        turn = {16'd0, ang, 32'd0} >> 16;
        x    = ((turn & (ONE_Q30 - 1)) * HPI_Q30) >> 30;
        x2   = (x * x) >> 30;
        s    = (x * taylor_poly(x2, 1'b0)) >> 30;
        if (s > ONE_Q30) s = ONE_Q30;
        si = longint'(s);
        ci = longint'(taylor_poly(x2, 1'b1));
        case (turn[31:30])
            2'd0: begin sn = si;  cs = ci;  end
            2'd1: begin sn = ci;  cs = -si; end
            2'd2: begin sn = -si; cs = -ci; end
            default: begin sn = -ci; cs = si; end
        endcase
    endtask

    // Q30 product, floored
    function automatic longint q30_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0) return p >>> 30;
        return -longint'((unsigned'(-p) + (ONE_Q30 - 1)) >> 30);
    endfunction

    function automatic logic [31:0] sat_signed(input longint unsigned mag, input bit neg);
        if (neg) begin
            if (mag >= 64'h8000_0000) return 32'h8000_0000;
            return 32'((64'h1_0000_0000 - mag) & 64'hFFFF_FFFF);
        end
        if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return 32'(mag);
    endfunction

    function automatic logic [31:0] scaled_comp(input longint b, input logic [15:0] sz);
        longint unsigned mag;
        longint unsigned r;
        mag = (b < 0) ? unsigned'(-b) : unsigned'(b);
        r   = (mag * sz + (64'd1 << 21)) >> 22;
        return sat_signed(r, (b < 0) && (r != 0));
    endfunction

    function automatic logic [31:0] inv_scaled_comp(input longint b, input logic [15:0] sz);
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        mag = (b < 0) ? unsigned'(-b) : unsigned'(b);
        if (sz == 0) begin
            if (mag == 0) return 32'd0;
            return (b < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        den = 64'(sz) << 30;
        q   = ((mag << 24) + (den >> 1)) / den;
        return sat_signed(q, (b < 0) && (q != 0));
    endfunction

    task automatic predict_columns(input t_in_word w);
        longint      s1, c1, s2, c2, s3, c3;
        longint      bas[3][3];
        logic [15:0] sz;
        t_out_word   col;
        angle_sincos(w.angle_y, s1, c1);
        angle_sincos(w.angle_x, s2, c2);
        angle_sincos(w.angle_z, s3, c3);
        bas[0][0] = q30_mul(c1, c3) + q30_mul(q30_mul(s1, s2), s3);
        bas[0][1] = q30_mul(c2, s3);
        bas[0][2] = q30_mul(q30_mul(c1, s2), s3) - q30_mul(c3, s1);
        bas[1][0] = q30_mul(q30_mul(c3, s1), s2) - q30_mul(c1, s3);
        bas[1][1] = q30_mul(c2, c3);
        bas[1][2] = q30_mul(q30_mul(c1, c3), s2) + q30_mul(s1, s3);
        bas[2][0] = q30_mul(c2, s1);
        bas[2][1] = -s2;
        bas[2][2] = q30_mul(c1, c2);
        for (int c = 0; c < 3; c++) begin
            sz = (c == 0) ? w.size_x : (c == 1) ? w.size_y : w.size_z;
            col.column_index = 2'(c);
            col.model_cx     = scaled_comp(bas[c][0], sz);
            col.model_cy     = scaled_comp(bas[c][1], sz);
            col.model_cz     = scaled_comp(bas[c][2], sz);
            col.normal_cx    = inv_scaled_comp(bas[c][0], sz);
            col.normal_cy    = inv_scaled_comp(bas[c][1], sz);
            col.normal_cz    = inv_scaled_comp(bas[c][2], sz);
            col.scale_fault  = (sz == 0);
            col.last_column  = 1'b0;
            column_q.push_back(col);
        end
        col              = '0;
        col.column_index = COL_MOVE;
        col.model_cx     = w.move_x;
        col.model_cy     = w.move_y;
        col.model_cz     = w.move_z;
        col.last_column  = 1'b1;
        column_q.push_back(col);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an optional long hold-off.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic field_cmp(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", fname, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // Column checker: every accepted output word against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && i_ready) begin
            if (column_q.size() == 0) begin
                $error("output word with nothing expected: %h", o_word);
                err_cnt++;
            end else begin
                e = column_q.pop_front();
                field_cmp("column_index", e.column_index, o_word.column_index);
                field_cmp("model_cx", e.model_cx, o_word.model_cx);
                field_cmp("model_cy", e.model_cy, o_word.model_cy);
                field_cmp("model_cz", e.model_cz, o_word.model_cz);
                field_cmp("normal_cx", e.normal_cx, o_word.normal_cx);
                field_cmp("normal_cy", e.normal_cy, o_word.normal_cy);
                field_cmp("normal_cz", e.normal_cz, o_word.normal_cz);
                field_cmp("scale_fault", e.scale_fault, o_word.scale_fault);
                field_cmp("last_column", e.last_column, o_word.last_column);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: one transform word, with a random gap ahead of it.
    // ------------------------------------------------------------------
    task automatic send_transform(input t_in_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (!o_ready);
        predict_columns(w);
    endtask

    function automatic t_in_word mk_word(input logic [15:0] ax, input logic [15:0] ay,
                                         input logic [15:0] az, input logic [15:0] sx,
                                         input logic [15:0] sy, input logic [15:0] sz);
        t_in_word w;
        w.angle_x = ax; w.angle_y = ay; w.angle_z = az;
        w.move_x  = $urandom; w.move_y = $urandom; w.move_z = $urandom;
        w.size_x  = sx; w.size_y = sy; w.size_z = sz;
        return w;
    endfunction

    // angles biased towards quadrant edges, where the series and sign flips matter
    function automatic logic [15:0] pick_angle();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(3)) * 16'h4000 + 16'($urandom_range(2)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 8));
            3:       return 16'h0100;
            default: return 16'($urandom);
        endcase
    endfunction

    // extremes: zero and full angles, unit/min/max/zero scale, extreme moves
    task automatic test_extremes();
        t_in_word w;
        send_transform(mk_word(0, 0, 0, 16'h0100, 16'h0100, 16'h0100));
        send_transform(mk_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_transform(mk_word(0, 0, 0, 16'd1, 16'd1, 16'd1));
        w = mk_word(16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
        w.move_x = 32'sh7FFF_FFFF; w.move_y = 32'sh8000_0000; w.move_z = 0;
        send_transform(w);
        w = mk_word(16'h1234, 16'hC000, 16'h4000, 0, 16'h0100, 0);
        w.move_x = 32'sh8000_0000; w.move_y = 32'sh7FFF_FFFF; w.move_z = -1;
        send_transform(w);
    endtask

    // each quadrant per axis, and zero scale on a single column
    task automatic test_quadrants();
        for (int q = 0; q < 4; q++) begin
            send_transform(mk_word(16'(q) << 14, 0, 0, 16'h0100, 16'h0080, 16'h0200));
            send_transform(mk_word(0, 16'(q) << 14, 0, 16'h0100, 16'h0080, 16'h0200));
            send_transform(mk_word(0, 0, 16'(q) << 14, 16'h0100, 16'h0080, 16'h0200));
            send_transform(mk_word(16'(q) << 14 | 16'h2000, 16'h1FFF, 16'hE001,
                                   (q == 0) ? 16'd0 : 16'h0300,
                                   (q == 1) ? 16'd0 : 16'h0001,
                                   (q == 2) ? 16'd0 : 16'hFFFF));
        end
    endtask

    task automatic test_random(input int n, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int k = 0; k < n; k++)
            send_transform(mk_word(pick_angle(), pick_angle(), pick_angle(),
                                   pick_size(), pick_size(), pick_size()));
    endtask

    // long receiver hold-off while the sender keeps offering words
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold     = 400;
        for (int k = 0; k < 30; k++)
            send_transform(mk_word(pick_angle(), pick_angle(), pick_angle(),
                                   pick_size(), pick_size(), pick_size()));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_quadrants();
        test_random(80, 21, 69);
        test_random(80, 69, 21);
        test_random(60, 0, 0);
        test_backpressure();
        i_valid <= 1'b0;
        while (column_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (err_cnt == 0)
            $display("euler_model_normal_matrix_unit_tb: done, clean");
        else
            $display("euler_model_normal_matrix_unit_tb: done, errors");
        $finish;
    end

endmodule
